FILE: rtl/als_pkg.sv
package als_pkg;

    localparam int BITS_PER_PIXEL = 24;
    localparam int COLOR_W        = 24;
    localparam int TICK_W         = 16;
    localparam int BITS_W         = $clog2(BITS_PER_PIXEL + 1);
    localparam int COLOR_IDX_W    = $clog2(COLOR_W);
    localparam int REG_IDX_W      = 3;
    localparam int PADDR_W        = REG_IDX_W + 2;

    // register indexes, byte address = 4 * index
    localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LATCH     = 3'd4;

    localparam logic [TICK_W-1:0] RST_ONE_HIGH  = 16'd11;
    localparam logic [TICK_W-1:0] RST_ONE_LOW   = 16'd3;
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH = 16'd4;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW  = 16'd11;
    localparam logic [TICK_W-1:0] RST_LATCH     = 16'd560;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] latch;
    } t_cfg;

    typedef struct packed {
        logic data_pin;
        logic accepted;
        logic frame_done;
        logic busy_res;
    } t_res;

    // zero length counts as one tick
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    // bit under transmission; bits above the color word go out as zeros
    function automatic logic cur_bit(input logic [COLOR_W-1:0] word,
                                     input logic [BITS_W-1:0]  bits);
        logic [BITS_W-1:0] idx;
        idx = bits - BITS_W'(1);
        if (bits == '0) begin
            return 1'b0;
        end
        if (idx >= BITS_W'(COLOR_W)) begin
            return 1'b0;
        end
        return word[idx[COLOR_IDX_W-1:0]];
    endfunction

endpackage

FILE: rtl/als_in_if.sv
interface als_in_if import als_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [COLOR_W-1:0] color;
    logic               last_pixel;

    modport source (output valid, kind, color, last_pixel, input ready);
    modport sink   (input valid, kind, color, last_pixel, output ready);
endinterface

FILE: rtl/als_out_if.sv
interface als_out_if;
    logic valid;
    logic ready;
    logic data_pin;
    logic accepted;
    logic frame_done;
    logic busy_res;

    modport source (output valid, data_pin, accepted, frame_done, busy_res, input ready);
    modport sink   (input valid, data_pin, accepted, frame_done, busy_res, output ready);
endinterface

FILE: rtl/als_engine.sv
module als_engine import als_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_kind,
    input  logic [COLOR_W-1:0] i_color,
    input  logic               i_last_pixel,
    input  t_cfg               i_cfg,
    output t_res               o_res
);

    logic [COLOR_W-1:0] r_shift,      n_shift;
    logic [BITS_W-1:0]  r_bits,       n_bits;
    logic               r_low,        n_low;
    logic [TICK_W-1:0]  r_pc,         n_pc;
    logic [COLOR_W-1:0] r_pend_word,  n_pend_word;
    logic               r_pend_valid, n_pend_valid;
    logic               r_pend_last,  n_pend_last;
    logic               r_cur_last,   n_cur_last;
    logic               r_latching,   n_latching;
    logic [TICK_W-1:0]  r_latch_cnt,  n_latch_cnt;

    // state seen by a tick after a possible word start
    logic               start;
    logic [COLOR_W-1:0] s_word;
    logic [BITS_W-1:0]  s_bits;
    logic               s_low;
    logic [TICK_W-1:0]  s_pc;
    logic               s_last;
    logic               bit_val;
    logic [TICK_W-1:0]  phase_len;
    logic [TICK_W:0]    pc_inc;
    logic [TICK_W:0]    latch_inc;

    assign start   = (r_bits == '0) && r_pend_valid;
    assign s_word  = start ? r_pend_word : r_shift;
    assign s_bits  = start ? BITS_W'(BITS_PER_PIXEL) : r_bits;
    assign s_low   = start ? 1'b0 : r_low;
    assign s_pc    = start ? '0 : r_pc;
    assign s_last  = start ? r_pend_last : r_cur_last;
    assign bit_val = cur_bit(s_word, s_bits);

    always_comb begin
        if (s_low) begin
            phase_len = at_least_one(bit_val ? i_cfg.one_low : i_cfg.zero_low);
        end else begin
            phase_len = at_least_one(bit_val ? i_cfg.one_high : i_cfg.zero_high);
        end
    end

    assign pc_inc    = {1'b0, s_pc} + 17'd1;
    assign latch_inc = {1'b0, r_latch_cnt} + 17'd1;

    always_comb begin
        n_shift      = r_shift;
        n_bits       = r_bits;
        n_low        = r_low;
        n_pc         = r_pc;
        n_pend_word  = r_pend_word;
        n_pend_valid = r_pend_valid;
        n_pend_last  = r_pend_last;
        n_cur_last   = r_cur_last;
        n_latching   = r_latching;
        n_latch_cnt  = r_latch_cnt;
        o_res        = '0;
        if (i_fire) begin
            if (i_kind == KIND_LOAD) begin
                o_res.data_pin = (r_bits != '0) && !r_low;
                if (!r_pend_valid) begin
                    n_pend_word    = i_color;
                    n_pend_last    = i_last_pixel;
                    n_pend_valid   = 1'b1;
                    o_res.accepted = 1'b1;
                end
            end else if (r_latching) begin
                if (latch_inc >= {1'b0, at_least_one(i_cfg.latch)}) begin
                    n_latching       = 1'b0;
                    n_latch_cnt      = '0;
                    o_res.frame_done = 1'b1;
                end else begin
                    n_latch_cnt = latch_inc[TICK_W-1:0];
                end
            end else begin
                if (start) begin
                    n_shift      = r_pend_word;
                    n_cur_last   = r_pend_last;
                    n_pend_valid = 1'b0;
                    n_bits       = s_bits;
                    n_low        = 1'b0;
                    n_pc         = '0;
                end
                if (s_bits != '0) begin
                    o_res.data_pin = !s_low;
                    if (pc_inc >= {1'b0, phase_len}) begin
                        n_pc = '0;
                        if (!s_low) begin
                            n_low = 1'b1;
                        end else begin
                            n_low  = 1'b0;
                            n_bits = s_bits - BITS_W'(1);
                            if ((s_bits == BITS_W'(1)) && s_last) begin
                                n_latching  = 1'b1;
                                n_latch_cnt = '0;
                            end
                        end
                    end else begin
                        n_pc = pc_inc[TICK_W-1:0];
                    end
                end
            end
        end
        o_res.busy_res = (n_bits != '0) || n_latching;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift      <= '0;
            r_bits       <= '0;
            r_low        <= 1'b0;
            r_pc         <= '0;
            r_pend_word  <= '0;
            r_pend_valid <= 1'b0;
            r_pend_last  <= 1'b0;
            r_cur_last   <= 1'b0;
            r_latching   <= 1'b0;
            r_latch_cnt  <= '0;
        end else begin
            r_shift      <= n_shift;
            r_bits       <= n_bits;
            r_low        <= n_low;
            r_pc         <= n_pc;
            r_pend_word  <= n_pend_word;
            r_pend_valid <= n_pend_valid;
            r_pend_last  <= n_pend_last;
            r_cur_last   <= n_cur_last;
            r_latching   <= n_latching;
            r_latch_cnt  <= n_latch_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_from_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.frame_done |-> r_latching)
        else $error("frame_done without latch");

    a_latch_excl_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latching |-> (r_bits == '0))
        else $error("latching while shifting");

    a_refused_load_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_kind == KIND_LOAD) && r_pend_valid) |=> $stable(r_pend_word))
        else $error("refused load changed buffer");

    a_word_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_kind == KIND_TICK) && !r_latching && (r_bits == '0) && r_pend_valid)
        |=> (r_bits == BITS_W'(BITS_PER_PIXEL)) && !r_pend_valid)
        else $error("word start did not load shifter");
`endif

endmodule

FILE: rtl/addressable_led_serializer_core.sv
// Addressable LED serializer core (single-wire LED chain encoder).
// Input channel i_in: one word per handshake. kind=0 is a time tick that
// advances the line by one slot; kind=1 loads a 24-bit color word (with its
// last-of-frame mark) into the one-entry pending buffer.
// Output channel o_out: exactly one result word per input word, in order:
// data_pin (line level for the slot), accepted, frame_done, busy_res.
// Each result is held in the main result register, or in the skid
// register on a stall. One input word per cycle while i_in.ready is high;
// the whole per-word update is one compare-and-increment on the phase or
// latch counter between the state registers and the result register.
// Bit timing and latch length come from the APB registers (16-bit, at byte
// addresses 0x0..0x10); write them only while the block is idle.
// Reset (synchronous, active low) empties the buffers, stops any frame and
// restores the default timing (11/3, 4/11, latch 560).
// Receiver stall: a main result register plus a skid register hold up to
// two results; i_in.ready drops only when both are full, so nothing is
// lost or repeated.
module addressable_led_serializer_core import als_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    als_in_if.sink              i_in,
    als_out_if.source           o_out,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [PADDR_W-1:0]  i_paddr,
    input  logic [31:0]         i_pwdata,
    output logic [31:0]         o_prdata,
    output logic                o_pready
);

    // ---------------- configuration registers ----------------
    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    logic [TICK_W-1:0]    rd_val;

    assign reg_idx  = i_paddr[PADDR_W-1:2];
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_high  <= RST_ONE_HIGH;
            r_cfg.one_low   <= RST_ONE_LOW;
            r_cfg.zero_high <= RST_ZERO_HIGH;
            r_cfg.zero_low  <= RST_ZERO_LOW;
            r_cfg.latch     <= RST_LATCH;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ONE_HIGH:  r_cfg.one_high  <= i_pwdata[TICK_W-1:0];
                REG_ONE_LOW:   r_cfg.one_low   <= i_pwdata[TICK_W-1:0];
                REG_ZERO_HIGH: r_cfg.zero_high <= i_pwdata[TICK_W-1:0];
                REG_ZERO_LOW:  r_cfg.zero_low  <= i_pwdata[TICK_W-1:0];
                REG_LATCH:     r_cfg.latch     <= i_pwdata[TICK_W-1:0];
                default: ;   // unmapped: write dropped
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ONE_HIGH:  rd_val = r_cfg.one_high;
            REG_ONE_LOW:   rd_val = r_cfg.one_low;
            REG_ZERO_HIGH: rd_val = r_cfg.zero_high;
            REG_ZERO_LOW:  rd_val = r_cfg.zero_low;
            REG_LATCH:     rd_val = r_cfg.latch;
            default:       rd_val = '0;
        endcase
    end
    assign o_prdata = {{(32 - TICK_W){1'b0}}, rd_val};

    // ---------------- encoder state ----------------
    logic in_fire;
    t_res res;

    assign in_fire = i_in.valid && i_in.ready;

    als_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_kind       (i_in.kind),
        .i_color      (i_in.color),
        .i_last_pixel (i_in.last_pixel),
        .i_cfg        (r_cfg),
        .o_res        (res)
    );

    // ---------------- result register + skid ----------------
    t_res r_out;
    logic r_out_valid;
    t_res r_skid;
    logic r_skid_valid;
    logic out_pop;

    assign out_pop    = r_out_valid && o_out.ready;
    assign i_in.ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_pop) begin
            // head slot free this cycle: refill from skid first
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_pop) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (in_fire && r_out_valid && !out_pop) begin
            r_skid <= res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.data_pin   = r_out.data_pin;
    assign o_out.accepted   = r_out.accepted;
    assign o_out.frame_done = r_out.frame_done;
    assign o_out.busy_res   = r_out.busy_res;

`ifndef NO_ASSERTIONS
    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid full with head empty");

    a_stall_fill_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_out_valid && !o_out.ready) |=> r_skid_valid)
        else $error("stalled result not parked in skid");

    a_out_follows_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !r_skid_valid) |=> r_out_valid)
        else $error("accepted word produced no result");
`endif

endmodule

FILE: tb/addressable_led_serializer_core_tb.sv
`timescale 1ns / 1ps

module addressable_led_serializer_core_tb;
    import als_pkg::*;

    // Run control
    localparam int ITEMS_PER_PHASE = 72;    // random words per random phase
    localparam int RAND_PHASES     = 8;
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
    localparam int ERR_PRINT_MAX   = 100;   // cap on printed mismatches
    localparam int RUN_LIMIT_NS    = 60_000_000;

    // Pacing of the two channel sides
    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } t_pace;

    // One word on the input channel
    typedef struct {
        logic               kind;
        logic [COLOR_W-1:0] color;
        logic               last_pixel;
    } t_led_word;

    logic i_clk;
    logic i_rst_n;
    logic               i_psel;
    logic               i_penable;
    logic               i_pwrite;
    logic [PADDR_W-1:0] i_paddr;
    logic [31:0]        i_pwdata;
    logic [31:0]        o_prdata;
    logic               o_pready;

    als_in_if  led_in ();
    als_out_if led_out ();

    addressable_led_serializer_core i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (led_in),
        .o_out     (led_out),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // Stimulus and scoreboard storage
    t_led_word line_words_q[$];     // words waiting to be offered
    t_res      expected_res_q[$];   // predicted results, oldest first
    t_led_word offered;             // word currently on the input channel
    int        mismatch_cnt;
    int        send_idle_pct;
    int        recv_stall_pct;
    logic      hold_go = 1'b0;
    logic      hold_active = 1'b0;

    // -----------------------------------------------------------------
    // Line encoder predictor: own copy of timing registers and state
    // -----------------------------------------------------------------
    t_cfg               timing;
    logic [COLOR_W-1:0] shreg;         // word being shifted out
    logic [BITS_W-1:0]  bits_rem;      // bits still to send, 0 = not shifting
    logic               low_phase;     // second (low) half of the bit
    logic [TICK_W-1:0]  phase_cnt;
    logic [COLOR_W-1:0] held_word;     // one-entry buffer
    logic               held_full;
    logic               held_last;
    logic               word_is_last;  // current word ends the frame
    logic               in_latch;
    logic [TICK_W-1:0]  latch_cnt;

    task automatic reset_predictor();
        timing.one_high  = RST_ONE_HIGH;
        timing.one_low   = RST_ONE_LOW;
        timing.zero_high = RST_ZERO_HIGH;
        timing.zero_low  = RST_ZERO_LOW;
        timing.latch     = RST_LATCH;
        shreg        = '0;
        bits_rem     = '0;
        low_phase    = 1'b0;
        phase_cnt    = '0;
        held_word    = '0;
        held_full    = 1'b0;
        held_last    = 1'b0;
        word_is_last = 1'b0;
        in_latch     = 1'b0;
        latch_cnt    = '0;
    endtask

    // a programmed length of zero still lasts one tick
    function automatic logic [TICK_W-1:0] min_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    // level of the bit now on the line; pad bits above the color are zero
    function automatic logic bit_now();
        int idx;
        if (bits_rem == '0) begin
            return 1'b0;
        end
        idx = int'(bits_rem) - 1;
        if (idx >= COLOR_W) begin
            return 1'b0;
        end
        return shreg[idx];
    endfunction

    function automatic logic [TICK_W-1:0] phase_len();
        logic b;
        b = bit_now();
        if (low_phase) begin
            return min_one(b ? timing.one_low : timing.zero_low);
        end
        return min_one(b ? timing.one_high : timing.zero_high);
    endfunction

    // advance the encoder by one input word, return the line result
    function automatic t_res predict_slot(input t_led_word w);
        t_res r;
        r = '0;
        if (w.kind == KIND_LOAD) begin
            r.data_pin = (bits_rem != '0) && !low_phase;
            if (!held_full) begin
                held_word  = w.color;
                held_last  = w.last_pixel;
                held_full  = 1'b1;
                r.accepted = 1'b1;
            end
        end else if (in_latch) begin
            if (latch_cnt + 1 >= min_one(timing.latch)) begin
                in_latch     = 1'b0;
                latch_cnt    = '0;
                r.frame_done = 1'b1;
            end else begin
                latch_cnt = latch_cnt + 1'b1;
            end
        end else begin
            // buffered word starts on this very tick, no gap between words
            if (bits_rem == '0 && held_full) begin
                shreg        = held_word;
                word_is_last = held_last;
                held_full    = 1'b0;
                bits_rem     = BITS_W'(BITS_PER_PIXEL);
                low_phase    = 1'b0;
                phase_cnt    = '0;
            end
            if (bits_rem != '0) begin
                r.data_pin = !low_phase;
                if (phase_cnt + 1 >= phase_len()) begin
                    phase_cnt = '0;
                    if (!low_phase) begin
                        low_phase = 1'b1;
                    end else begin
                        low_phase = 1'b0;
                        bits_rem  = bits_rem - 1'b1;
                        if (bits_rem == '0 && word_is_last) begin
                            in_latch  = 1'b1;
                            latch_cnt = '0;
                        end
                    end
                end else begin
                    phase_cnt = phase_cnt + 1'b1;
                end
            end
        end
        r.busy_res = (bits_rem != '0) || in_latch;
        return r;
    endfunction

    // -----------------------------------------------------------------
    // Clock
    // -----------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // -----------------------------------------------------------------
    // Driver: offers queued words; predicts each one as it is taken
    // -----------------------------------------------------------------
    always @(posedge i_clk) begin : word_driver
        logic take;
        if (!i_rst_n) begin
            led_in.valid <= 1'b0;
        end else begin
            take = led_in.valid && led_in.ready;
            if (take) begin
                expected_res_q.push_back(predict_slot(offered));
            end
            // one assignment to valid per edge, so back-to-back words stay high
            if (!led_in.valid || take) begin
                if (line_words_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = line_words_q.pop_front();
                    led_in.valid      <= 1'b1;
                    led_in.kind       <= offered.kind;
                    led_in.color      <= offered.color;
                    led_in.last_pixel <= offered.last_pixel;
                end else begin
                    led_in.valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------
    // Monitor: compares each result word with the oldest prediction
    // -----------------------------------------------------------------
    task automatic check_field(input string fname, input logic exp_v, input logic got_v);
        if (got_v !== exp_v) begin
            if (mismatch_cnt < ERR_PRINT_MAX) begin
                $error("%s: expected %0b, got %0b", fname, exp_v, got_v);
            end
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_res exp_r;
        if (!i_rst_n) begin
            led_out.ready <= 1'b0;
        end else begin
            if (led_out.valid && led_out.ready) begin
                if (expected_res_q.size() == 0) begin
                    if (mismatch_cnt < ERR_PRINT_MAX) begin
                        $error("result word with no prediction waiting");
                    end
                    mismatch_cnt++;
                end else begin
                    exp_r = expected_res_q.pop_front();
                    check_field("data_pin",   exp_r.data_pin,   led_out.data_pin);
                    check_field("accepted",   exp_r.accepted,   led_out.accepted);
                    check_field("frame_done", exp_r.frame_done, led_out.frame_done);
                    check_field("busy_res",   exp_r.busy_res,   led_out.busy_res);
                end
            end
            led_out.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off: the core fills both result slots and
    // must drop i_in.ready while the sender keeps offering words
    initial begin : receiver_hold
        wait (hold_go);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    // Watchdog
    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("addressable_led_serializer_core: mismatch");
        $finish;
    end

    // -----------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------
    task automatic set_pace(input t_pace p);
        case (p)
            PACE_FULL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            PACE_SEND_IDLE: begin
                send_idle_pct  = 78;
                recv_stall_pct = 0;
            end
            PACE_RECV_STALL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 78;
            end
            default: begin
                send_idle_pct  = 32;
                recv_stall_pct = 32;
            end
        endcase
    endtask

    // APB write: setup, access, register taken at the access edge
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        // only the low 16 bits are kept; spare indexes do nothing
        case (idx)
            REG_ONE_HIGH:  timing.one_high  = data[TICK_W-1:0];
            REG_ONE_LOW:   timing.one_low   = data[TICK_W-1:0];
            REG_ZERO_HIGH: timing.zero_high = data[TICK_W-1:0];
            REG_ZERO_LOW:  timing.zero_low  = data[TICK_W-1:0];
            REG_LATCH:     timing.latch     = data[TICK_W-1:0];
            default: ;
        endcase
    endtask

    // upper data bits are random junk the core must drop
    task automatic set_timing(input logic [TICK_W-1:0] oh, input logic [TICK_W-1:0] ol,
                              input logic [TICK_W-1:0] zh, input logic [TICK_W-1:0] zl,
                              input logic [TICK_W-1:0] lt);
        apb_write(REG_ONE_HIGH,  {16'($urandom), oh});
        apb_write(REG_ONE_LOW,   {16'($urandom), ol});
        apb_write(REG_ZERO_HIGH, {16'($urandom), zh});
        apb_write(REG_ZERO_LOW,  {16'($urandom), zl});
        apb_write(REG_LATCH,     {16'($urandom), lt});
    endtask

    task automatic push_ticks(input int n);
        t_led_word w;
        w = '{KIND_TICK, COLOR_W'($urandom), 1'($urandom)};
        repeat (n) line_words_q.push_back(w);
    endtask

    task automatic push_load(input logic [COLOR_W-1:0] color, input logic last_pixel);
        line_words_q.push_back('{KIND_LOAD, color, last_pixel});
    endtask

    // random mix of ticks and color loads; loads often hit a full buffer
    task automatic push_random(input int n, input int load_pct);
        logic [COLOR_W-1:0] c;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < load_pct) begin
                case ($urandom_range(7))
                    0:       c = '0;
                    1:       c = '1;
                    default: c = COLOR_W'($urandom);
                endcase
                push_load(c, $urandom_range(99) < 30);
            end else begin
                push_ticks(1);
            end
        end
    endtask

    // sender stays quiet until every predicted result has come back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (line_words_q.size() != 0 || led_in.valid || expected_res_q.size() != 0);
    endtask

    function automatic logic [TICK_W-1:0] pick_len();
        case ($urandom_range(4))
            0:       return '0;
            1:       return TICK_W'(1);
            default: return TICK_W'($urandom_range(2, 5));
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] pick_latch();
        case ($urandom_range(3))
            0:       return '0;
            1:       return TICK_W'(1);
            default: return TICK_W'($urandom_range(2, 40));
        endcase
    endfunction

    // -----------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------
    initial begin : stimulus
        int load_pct;
        i_rst_n           = 1'b0;
        i_psel            = 1'b0;
        i_penable         = 1'b0;
        i_pwrite          = 1'b0;
        i_paddr           = '0;
        i_pwdata          = '0;
        led_in.valid      = 1'b0;
        led_in.kind       = KIND_TICK;
        led_in.color      = '0;
        led_in.last_pixel = 1'b0;
        led_out.ready     = 1'b0;
        mismatch_cnt      = 0;
        reset_predictor();
        set_pace(PACE_FULL);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // Directed, on reset timing (zero bit 4/11, one bit 11/3, latch 560)
        set_pace(PACE_BOTH);
        push_ticks(1);                  // idle tick drives low
        push_load(24'h000000, 1'b0);    // into the buffer
        push_load(24'hFFFFFF, 1'b1);    // buffer full: refused
        push_ticks(1);                  // word starts on this tick
        push_load(24'hFFFFFF, 1'b1);    // queued behind the shifting word
        push_load(24'hA5C33C, 1'b0);    // refused again
        push_ticks(370);                // first word out, second one just started
        wait_idle();

        // Short timing taken mid-word; latch, load during latch, underrun
        set_timing(16'd2, 16'd1, 16'd1, 16'd2, 16'd6);
        push_ticks(72);                 // rest of the word, then into the latch
        push_load(24'h5A5A5A, 1'b0);    // waits out the latch
        push_ticks(90);                 // latch ends, word shifts, then underrun
        push_load(24'h123456, 1'b1);    // restart after underrun
        push_ticks(90);
        wait_idle();

        // Zero lengths count as one tick; spare indexes are ignored
        set_pace(PACE_FULL);
        set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        for (int idx = int'(REG_LATCH) + 1; idx < (1 << REG_IDX_W); idx++) begin
            apb_write(REG_IDX_W'(idx), $urandom);   // spare indexes: ignored
        end
        push_load(24'h000001, 1'b1);
        push_ticks(52);
        wait_idle();

        // Full-scale lengths, cut short by shrinking them mid-phase
        set_timing(16'hFFFF, 16'd1, 16'd0, 16'd1, 16'hFFFF);
        push_load(24'h000001, 1'b1);
        push_ticks(60);                 // long high phase of the final one bit
        wait_idle();
        set_timing(16'd2, 16'd1, 16'd0, 16'd1, 16'hFFFF);
        push_ticks(20);                 // bit ends, long latch starts
        wait_idle();
        set_timing(16'd2, 16'd1, 16'd0, 16'd1, 16'd3);
        push_ticks(4);                  // latch already past its length
        wait_idle();

        set_timing(16'd0, 16'd0, 16'd1, 16'hFFFF, 16'd1);
        push_load(24'hFFFFFE, 1'b1);
        push_ticks(1);
        push_load(24'hFFFFFF, 1'b1);
        push_ticks(60);                 // long low phase of the final zero bit
        wait_idle();
        set_timing(16'd0, 16'd0, 16'd1, 16'd2, 16'd1);
        push_ticks(52);                 // second word and its latch
        wait_idle();

        // Random phases: short timings, every pacing mode in turn
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_pace(t_pace'(ph % 4));
            set_timing(pick_len(), pick_len(), pick_len(), pick_len(), pick_latch());
            load_pct = $urandom_range(3, 30);
            push_random(ITEMS_PER_PHASE / 2, load_pct);
            if (ph == 0) begin
                hold_go = 1'b1;
            end
            wait_idle();
            push_random(ITEMS_PER_PHASE / 2, load_pct);
            wait_idle();
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_res_q.size() == 0) begin
            $display("addressable_led_serializer_core: match");
        end else begin
            $display("addressable_led_serializer_core: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/als_pkg.sv
rtl/als_in_if.sv
rtl/als_out_if.sv
rtl/als_engine.sv
rtl/addressable_led_serializer_core.sv
tb/addressable_led_serializer_core_tb.sv
